>>> design/hdcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdcc_pkg
// Shared types, register map and text helpers for the calendar clock.
// ----------------------------------------------------------------------------
package hdcc_pkg;

  localparam int unsigned NUM_REGS   = 7;
  localparam int unsigned ADDR_W     = 5;
  localparam int unsigned YEAR_W     = 14;
  localparam int unsigned BCD_W      = 16;
  localparam int unsigned APPLIED_W  = 8;
  localparam logic [7:0]  ASCII_ZERO = 8'd48;

  localparam logic [2:0] REG_START_YEAR    = 3'd0;
  localparam logic [2:0] REG_START_MONTH   = 3'd1;
  localparam logic [2:0] REG_START_DAY     = 3'd2;
  localparam logic [2:0] REG_START_HOUR    = 3'd3;
  localparam logic [2:0] REG_START_MINUTE  = 3'd4;
  localparam logic [2:0] REG_START_SECOND  = 3'd5;
  localparam logic [2:0] REG_START_WEEKDAY = 3'd6;

  localparam logic [13:0] MAX_YEAR     = 14'd9999;
  localparam logic [3:0]  MONTHS       = 4'd12;
  localparam logic [4:0]  HOURS_LAST   = 5'd23;
  localparam logic [5:0]  SIXTY_LAST   = 6'd59;
  localparam logic [2:0]  WEEKDAY_LAST = 3'd6;
  localparam logic [3:0]  CONV_LAST    = 4'(YEAR_W - 1);

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
  } start_cfg_t;

  typedef struct packed {
    logic start_adv;
    logic start_load;
    logic conv_step;
    logic tick;
    logic capture;
  } hdcc_cmd_t;

  typedef struct packed {
    logic rem_zero;
    logic conv_last;
  } hdcc_sts_t;

  function automatic logic [15:0] two_digits(input logic [5:0] v);
    logic [9:0] prod;
    logic [2:0] tens;
    logic [5:0] ones;
    begin
      prod = 10'(v) * 10'd13;
      tens = prod[9:7];
      ones = v - 6'(tens) * 6'd10;
      return {ASCII_ZERO | 8'(tens), ASCII_ZERO | 8'(ones[3:0])};
    end
  endfunction

  function automatic logic div4_pair(input logic [3:0] t, input logic [3:0] o);
    begin
      if (!t[0]) begin
        return (o == 4'd0) || (o == 4'd4) || (o == 4'd8);
      end
      return (o == 4'd2) || (o == 4'd6);
    end
  endfunction

  function automatic logic is_leap(input logic [15:0] y);
    logic cent;
    begin
      cent = (y[7:4] == 4'd0) && (y[3:0] == 4'd0);
      return div4_pair(y[7:4], y[3:0]) && (!cent || div4_pair(y[15:12], y[11:8]));
    end
  endfunction

  function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic leap);
    begin
      case (m)
        4'd2:                      return leap ? 5'd29 : 5'd28;
        4'd4, 4'd6, 4'd9, 4'd11:   return 5'd30;
        default:                   return 5'd31;
      endcase
    end
  endfunction

  function automatic logic [23:0] weekday_name(input logic [2:0] w);
    begin
      case (w)
        3'd1:    return "Mon";
        3'd2:    return "Tue";
        3'd3:    return "Wed";
        3'd4:    return "Thu";
        3'd5:    return "Fri";
        3'd6:    return "Sat";
        default: return "Sun";
      endcase
    end
  endfunction

  function automatic logic [23:0] month_name(input logic [3:0] m);
    begin
      case (m)
        4'd1, 4'd13: return "Jan";
        4'd2, 4'd14: return "Feb";
        4'd3, 4'd15: return "Mar";
        4'd5:        return "May";
        4'd6:        return "Jun";
        4'd7:        return "Jul";
        4'd8:        return "Aug";
        4'd9:        return "Sep";
        4'd10:       return "Oct";
        4'd11:       return "Nov";
        4'd12:       return "Dec";
        default:     return "Apr";
      endcase
    end
  endfunction

endpackage

>>> design/hdcc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdcc_ctrl
// Sequencer: takes a request, runs the year conversion or the second ticks,
// then hands the result to the output register.
// ----------------------------------------------------------------------------
module hdcc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_op,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  input  hdcc_pkg::hdcc_sts_t sts,
  output hdcc_pkg::hdcc_cmd_t cmd
);
  import hdcc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_TICK = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op) begin
            cmd.start_load = 1'b1;
            state_nxt      = ST_CONV;
          end else begin
            cmd.start_adv = 1'b1;
            state_nxt     = ST_TICK;
          end
        end
      end
      ST_CONV: begin
        cmd.conv_step = 1'b1;
        if (sts.conv_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_TICK: begin
        if (sts.rem_zero) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.tick = 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.capture) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> design/hdcc_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdcc_dpath
// Calendar counters, year conversion to decimal, tick carries and the
// registered result text.
// ----------------------------------------------------------------------------
module hdcc_dpath #(
  parameter int unsigned ELAPSED_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  hdcc_pkg::hdcc_cmd_t         cmd,
  output hdcc_pkg::hdcc_sts_t         sts,
  input  hdcc_pkg::start_cfg_t        cfg,
  input  logic [ELAPSED_BITS-1:0]     in_elapsed_seconds,
  output logic [23:0]                 out_weekday_text,
  output logic [15:0]                 out_day_text,
  output logic [23:0]                 out_month_text,
  output logic [31:0]                 out_year_text,
  output logic [15:0]                 out_hour_text,
  output logic [15:0]                 out_minute_text,
  output logic [15:0]                 out_second_text,
  output logic [7:0]                  out_seconds_applied
);
  import hdcc_pkg::*;

  logic [5:0]  sec_r, sec_nxt;
  logic [5:0]  min_r, min_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [2:0]  wday_r, wday_nxt;
  logic [4:0]  day_r, day_nxt;
  logic [3:0]  mon_r, mon_nxt;
  logic [15:0] year_r, year_nxt;
  logic [13:0] ybin_r, ybin_nxt;
  logic [3:0]  conv_cnt_r, conv_cnt_nxt;
  logic [ELAPSED_BITS-1:0] rem_r, rem_nxt;
  logic [APPLIED_W-1:0]    applied_r, applied_nxt;

  logic [15:0] year_inc;
  logic [15:0] bcd_adj;
  logic        carry;

  logic [23:0] wtxt_r;
  logic [15:0] dtxt_r;
  logic [23:0] mtxt_r;
  logic [31:0] ytxt_r;
  logic [15:0] htxt_r;
  logic [15:0] itxt_r;
  logic [15:0] stxt_r;
  logic [7:0]  atxt_r;

  always_comb begin
    carry = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (carry) begin
        if (year_r[4*i +: 4] == 4'd9) begin
          year_inc[4*i +: 4] = 4'd0;
        end else begin
          year_inc[4*i +: 4] = year_r[4*i +: 4] + 4'd1;
          carry = 1'b0;
        end
      end else begin
        year_inc[4*i +: 4] = year_r[4*i +: 4];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      bcd_adj[4*i +: 4] = (year_r[4*i +: 4] >= 4'd5) ? year_r[4*i +: 4] + 4'd3
                                                     : year_r[4*i +: 4];
    end
  end

  always_comb begin
    sec_nxt      = sec_r;
    min_nxt      = min_r;
    hour_nxt     = hour_r;
    wday_nxt     = wday_r;
    day_nxt      = day_r;
    mon_nxt      = mon_r;
    year_nxt     = year_r;
    ybin_nxt     = ybin_r;
    conv_cnt_nxt = conv_cnt_r;
    rem_nxt      = rem_r;
    applied_nxt  = applied_r;
    if (cmd.start_adv) begin
      rem_nxt     = in_elapsed_seconds;
      applied_nxt = APPLIED_W'(in_elapsed_seconds);
    end
    if (cmd.start_load) begin
      applied_nxt  = '0;
      ybin_nxt     = (cfg.year > MAX_YEAR) ? MAX_YEAR : cfg.year;
      year_nxt     = '0;
      conv_cnt_nxt = '0;
      mon_nxt      = (cfg.month == 4'd0) ? 4'd1 : ((cfg.month > MONTHS) ? MONTHS : cfg.month);
      day_nxt      = (cfg.day == 5'd0) ? 5'd1 : cfg.day;
      hour_nxt     = (cfg.hour > HOURS_LAST) ? HOURS_LAST : cfg.hour;
      min_nxt      = (cfg.minute > SIXTY_LAST) ? SIXTY_LAST : cfg.minute;
      sec_nxt      = (cfg.second > SIXTY_LAST) ? SIXTY_LAST : cfg.second;
      wday_nxt     = (cfg.weekday > WEEKDAY_LAST) ? WEEKDAY_LAST : cfg.weekday;
    end
    if (cmd.conv_step) begin
      year_nxt     = {bcd_adj[14:0], ybin_r[YEAR_W-1]};
      ybin_nxt     = {ybin_r[YEAR_W-2:0], 1'b0};
      conv_cnt_nxt = conv_cnt_r + 4'd1;
    end
    if (cmd.tick) begin
      rem_nxt = rem_r - ELAPSED_BITS'(1);
      if (sec_r != SIXTY_LAST) begin
        sec_nxt = sec_r + 6'd1;
      end else begin
        sec_nxt = '0;
        if (min_r != SIXTY_LAST) begin
          min_nxt = min_r + 6'd1;
        end else begin
          min_nxt = '0;
          if (hour_r < HOURS_LAST) begin
            hour_nxt = hour_r + 5'd1;
          end else begin
            hour_nxt = '0;
            wday_nxt = (wday_r >= WEEKDAY_LAST) ? 3'd0 : wday_r + 3'd1;
            if (day_r < days_in_month(mon_r, is_leap(year_r))) begin
              day_nxt = day_r + 5'd1;
            end else begin
              day_nxt = 5'd1;
              if (mon_r < MONTHS) begin
                mon_nxt = mon_r + 4'd1;
              end else begin
                mon_nxt  = 4'd1;
                year_nxt = year_inc;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r      <= '0;
      min_r      <= '0;
      hour_r     <= '0;
      wday_r     <= 3'd4;
      day_r      <= 5'd1;
      mon_r      <= 4'd1;
      year_r     <= 16'h1970;
      ybin_r     <= '0;
      conv_cnt_r <= '0;
      rem_r      <= '0;
      applied_r  <= '0;
    end else begin
      sec_r      <= sec_nxt;
      min_r      <= min_nxt;
      hour_r     <= hour_nxt;
      wday_r     <= wday_nxt;
      day_r      <= day_nxt;
      mon_r      <= mon_nxt;
      year_r     <= year_nxt;
      ybin_r     <= ybin_nxt;
      conv_cnt_r <= conv_cnt_nxt;
      rem_r      <= rem_nxt;
      applied_r  <= applied_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      wtxt_r <= weekday_name(wday_r);
      dtxt_r <= two_digits({1'b0, day_r});
      mtxt_r <= month_name(mon_r);
      ytxt_r <= {ASCII_ZERO | {4'd0, year_r[15:12]}, ASCII_ZERO | {4'd0, year_r[11:8]},
                 ASCII_ZERO | {4'd0, year_r[7:4]},   ASCII_ZERO | {4'd0, year_r[3:0]}};
      htxt_r <= two_digits({1'b0, hour_r});
      itxt_r <= two_digits(min_r);
      stxt_r <= two_digits(sec_r);
      atxt_r <= applied_r;
    end
  end

  assign sts.rem_zero  = (rem_r == '0);
  assign sts.conv_last = (conv_cnt_r == CONV_LAST);

  assign out_weekday_text    = wtxt_r;
  assign out_day_text        = dtxt_r;
  assign out_month_text      = mtxt_r;
  assign out_year_text       = ytxt_r;
  assign out_hour_text       = htxt_r;
  assign out_minute_text     = itxt_r;
  assign out_second_text     = stxt_r;
  assign out_seconds_applied = atxt_r;

endmodule

>>> design/http_date_calendar_clock.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_date_calendar_clock
// Gregorian calendar clock with HTTP-date text results and APB start registers.
//
//   channel  handshake               payload
//   in       in_valid / in_ready     in_op, in_elapsed_seconds
//   out      out_valid / out_ready   out_*_text, out_seconds_applied
//   cfg      psel, penable, pwrite   paddr, pwdata, prdata (pready tied high)
//
// A load request runs accept, 14 year conversion steps and the result.
// An advance request runs accept, one tick per second, the zero check and the
// result. One request at a time; a new request is taken while the previous
// result still waits in the output register. Reset is synchronous and gives the
// calendar counters Thu 01 Jan 1970 00:00:00 and the reset start values.
// ----------------------------------------------------------------------------
module http_date_calendar_clock #(
  parameter int unsigned ELAPSED_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_op,
  input  logic [ELAPSED_BITS-1:0] in_elapsed_seconds,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [23:0]             out_weekday_text,
  output logic [15:0]             out_day_text,
  output logic [23:0]             out_month_text,
  output logic [31:0]             out_year_text,
  output logic [15:0]             out_hour_text,
  output logic [15:0]             out_minute_text,
  output logic [15:0]             out_second_text,
  output logic [7:0]              out_seconds_applied,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [hdcc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import hdcc_pkg::*;

  start_cfg_t cfg_r, cfg_nxt;
  hdcc_cmd_t  cmd;
  hdcc_sts_t  sts;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_START_YEAR:    cfg_nxt.year    = pwdata[13:0];
        REG_START_MONTH:   cfg_nxt.month   = pwdata[3:0];
        REG_START_DAY:     cfg_nxt.day     = pwdata[4:0];
        REG_START_HOUR:    cfg_nxt.hour    = pwdata[4:0];
        REG_START_MINUTE:  cfg_nxt.minute  = pwdata[5:0];
        REG_START_SECOND:  cfg_nxt.second  = pwdata[5:0];
        REG_START_WEEKDAY: cfg_nxt.weekday = pwdata[2:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_START_YEAR:    prdata = 32'(cfg_r.year);
      REG_START_MONTH:   prdata = 32'(cfg_r.month);
      REG_START_DAY:     prdata = 32'(cfg_r.day);
      REG_START_HOUR:    prdata = 32'(cfg_r.hour);
      REG_START_MINUTE:  prdata = 32'(cfg_r.minute);
      REG_START_SECOND:  prdata = 32'(cfg_r.second);
      REG_START_WEEKDAY: prdata = 32'(cfg_r.weekday);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.year    <= 14'd1970;
      cfg_r.month   <= 4'd1;
      cfg_r.day     <= 5'd1;
      cfg_r.hour    <= '0;
      cfg_r.minute  <= '0;
      cfg_r.second  <= '0;
      cfg_r.weekday <= 3'd4;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  hdcc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  hdcc_dpath #(
    .ELAPSED_BITS (ELAPSED_BITS)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg                 (cfg_r),
    .in_elapsed_seconds  (in_elapsed_seconds),
    .out_weekday_text    (out_weekday_text),
    .out_day_text        (out_day_text),
    .out_month_text      (out_month_text),
    .out_year_text       (out_year_text),
    .out_hour_text       (out_hour_text),
    .out_minute_text     (out_minute_text),
    .out_second_text     (out_second_text),
    .out_seconds_applied (out_seconds_applied)
  );

endmodule
